>>> sv/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared widths, sector codes and stage control type of the HSV to RGB path.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int unsigned HUE_W                 = 16;
  localparam int unsigned CH_W                  = 13;
  localparam int unsigned CHANNEL_FRAC_BITS_DEF = 12;

  // hue sector, sixths of a full turn
  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_e;

  typedef struct packed {
    logic    valid;
    sector_e sector;
  } hsv2rgb_ctl_t;

endpackage

>>> sv/hsv_to_rgb_converter.sv
// Pipeline: a pixel accepted with start passes four register stages (prep, scale,
//   mix, output register) and then shows its result with valid_o.
// Throughput: one pixel per clock cycle, set by the fully pipelined stages;
//   busy is always low and the receiver cannot stall the output.
// Reset: rst_ni clears the stage control registers (valid bit and sector) only; payload registers keep data.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSVA to RGBA pixel converter, four-stage pipeline in fixed point.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
  parameter int unsigned CHANNEL_FRAC_BITS = hsv2rgb_pkg::CHANNEL_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]    hue_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]     saturation_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]     brightness_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]     alpha_in_i,
  output logic                             valid_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]     red_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]     green_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]     blue_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]     alpha_out_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned F  = CHANNEL_FRAC_BITS;
  localparam int unsigned CW = (F + 1 > CH_W) ? F + 1 : CH_W;
  localparam logic [CW-1:0] ONE_C = CW'(1) << F;

  hsv2rgb_ctl_t     ctl1, ctl2, ctl3;
  logic [F-1:0]     frac1;
  logic [F:0]       sat1, val1;
  logic [F:0]       oms2, sf2, s1f2, val2;
  logic [F:0]       p3, q3, t3, val3;
  logic [CH_W-1:0]  alpha1, alpha2, alpha3;
  logic [F:0]       r_sel, g_sel, b_sel;
  logic [CW-1:0]    r_ext, g_ext, b_ext;
  logic             valid_q;
  logic [CH_W-1:0]  red_d, red_q, green_d, green_q, blue_d, blue_q, alpha_q;

  // every pixel is taken, one per cycle
  assign busy = 1'b0;

  hsv2rgb_prep #(.CHANNEL_FRAC_BITS(CHANNEL_FRAC_BITS)) u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start & ~busy),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .alpha_i      (alpha_in_i),
    .ctl_o        (ctl1),
    .frac_o       (frac1),
    .sat_o        (sat1),
    .val_o        (val1),
    .alpha_o      (alpha1)
  );

  hsv2rgb_scale #(.CHANNEL_FRAC_BITS(CHANNEL_FRAC_BITS)) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl1),
    .frac_i  (frac1),
    .sat_i   (sat1),
    .val_i   (val1),
    .alpha_i (alpha1),
    .ctl_o   (ctl2),
    .oms_o   (oms2),
    .sf_o    (sf2),
    .s1f_o   (s1f2),
    .val_o   (val2),
    .alpha_o (alpha2)
  );

  hsv2rgb_mix #(.CHANNEL_FRAC_BITS(CHANNEL_FRAC_BITS)) u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl2),
    .oms_i   (oms2),
    .sf_i    (sf2),
    .s1f_i   (s1f2),
    .val_i   (val2),
    .alpha_i (alpha2),
    .ctl_o   (ctl3),
    .p_o     (p3),
    .q_o     (q3),
    .t_o     (t3),
    .val_o   (val3),
    .alpha_o (alpha3)
  );

  // channel routing per hue sector
  always_comb begin
    unique case (ctl3.sector)
      SEC_1: begin
        r_sel = q3;   g_sel = val3; b_sel = p3;
      end
      SEC_2: begin
        r_sel = p3;   g_sel = val3; b_sel = t3;
      end
      SEC_3: begin
        r_sel = p3;   g_sel = q3;   b_sel = val3;
      end
      SEC_4: begin
        r_sel = t3;   g_sel = p3;   b_sel = val3;
      end
      SEC_5: begin
        r_sel = val3; g_sel = p3;   b_sel = q3;
      end
      default: begin
        r_sel = val3; g_sel = t3;   b_sel = p3;
      end
    endcase
    r_ext   = CW'(r_sel);
    g_ext   = CW'(g_sel);
    b_ext   = CW'(b_sel);
    red_d   = r_ext[CH_W-1:0];
    green_d = g_ext[CH_W-1:0];
    blue_d  = b_ext[CH_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl3.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
    alpha_q <= alpha3;
  end

  assign valid_o     = valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_out_o = alpha_q;

  // an accepted transaction enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> ctl1.valid)
    else $error("accepted transaction lost at first stage");

  // hue * 6 stays below six full turns
  a_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl1.valid |-> (ctl1.sector == SEC_0 || ctl1.sector == SEC_1 ||
                    ctl1.sector == SEC_2 || ctl1.sector == SEC_3 ||
                    ctl1.sector == SEC_4 || ctl1.sector == SEC_5))
    else $error("hue sector out of range");

  a_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl3.valid |=> valid_o)
    else $error("transaction lost at output stage");

  // all channels stay within one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (CW'(red_o) <= ONE_C && CW'(green_o) <= ONE_C &&
                 CW'(blue_o) <= ONE_C))
    else $error("color channel above one");

endmodule

>>> sv/hsv2rgb_prep.sv
// ----------------------------------------------------------------------------
// hsv2rgb_prep
// Stage 1: hue sector and fraction, saturation and value limited to 1.0.
// ----------------------------------------------------------------------------
module hsv2rgb_prep #(
  parameter int unsigned CHANNEL_FRAC_BITS = hsv2rgb_pkg::CHANNEL_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]    hue_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]     saturation_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]     brightness_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]     alpha_i,
  output hsv2rgb_pkg::hsv2rgb_ctl_t        ctl_o,
  output logic [CHANNEL_FRAC_BITS-1:0]     frac_o,
  output logic [CHANNEL_FRAC_BITS:0]       sat_o,
  output logic [CHANNEL_FRAC_BITS:0]       val_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]     alpha_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned F  = CHANNEL_FRAC_BITS;
  localparam int unsigned CW = (F + 1 > CH_W) ? F + 1 : CH_W;
  localparam logic [CW-1:0] ONE_C = CW'(1) << F;

  logic [HUE_W+2:0]   h6;
  logic [CW-1:0]      sat_ext, val_ext;
  hsv2rgb_ctl_t       ctl_d, ctl_q;
  logic [F-1:0]       frac_d, frac_q;
  logic [F:0]         sat_d, sat_q, val_d, val_q;
  logic [CH_W-1:0]    alpha_q;

  always_comb begin
    // hue * 6 as two shifted adds
    h6           = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};
    ctl_d.valid  = valid_i;
    ctl_d.sector = sector_e'(h6[HUE_W+2:HUE_W]);
    frac_d       = h6[HUE_W-1 -: F];
    sat_ext      = CW'(saturation_i);
    val_ext      = CW'(brightness_i);
    sat_d        = (sat_ext > ONE_C) ? ONE_C[F:0] : sat_ext[F:0];
    val_d        = (val_ext > ONE_C) ? ONE_C[F:0] : val_ext[F:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, sector: SEC_0};
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frac_q  <= frac_d;
    sat_q   <= sat_d;
    val_q   <= val_d;
    alpha_q <= alpha_i;
  end

  assign ctl_o   = ctl_q;
  assign frac_o  = frac_q;
  assign sat_o   = sat_q;
  assign val_o   = val_q;
  assign alpha_o = alpha_q;

endmodule

>>> sv/hsv2rgb_scale.sv
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Stage 2: 1-s and the saturation products s*f and s*(1-f).
// ----------------------------------------------------------------------------
module hsv2rgb_scale #(
  parameter int unsigned CHANNEL_FRAC_BITS = hsv2rgb_pkg::CHANNEL_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hsv2rgb_pkg::hsv2rgb_ctl_t        ctl_i,
  input  logic [CHANNEL_FRAC_BITS-1:0]     frac_i,
  input  logic [CHANNEL_FRAC_BITS:0]       sat_i,
  input  logic [CHANNEL_FRAC_BITS:0]       val_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]     alpha_i,
  output hsv2rgb_pkg::hsv2rgb_ctl_t        ctl_o,
  output logic [CHANNEL_FRAC_BITS:0]       oms_o,
  output logic [CHANNEL_FRAC_BITS:0]       sf_o,
  output logic [CHANNEL_FRAC_BITS:0]       s1f_o,
  output logic [CHANNEL_FRAC_BITS:0]       val_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]     alpha_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned F = CHANNEL_FRAC_BITS;
  localparam logic [F:0] ONE_C = (F + 1)'(1) << F;

  logic [F:0]       omf;
  logic [2*F:0]     sf_prod;
  logic [2*F+1:0]   s1f_prod;
  logic [F:0]       oms_d, oms_q, sf_d, sf_q, s1f_d, s1f_q, val_q;
  logic [CH_W-1:0]  alpha_q;
  hsv2rgb_ctl_t     ctl_q;

  always_comb begin
    omf      = ONE_C - {1'b0, frac_i};
    sf_prod  = sat_i * frac_i;
    s1f_prod = sat_i * omf;
    oms_d    = ONE_C - sat_i;
    sf_d     = sf_prod[2*F:F];
    s1f_d    = s1f_prod[2*F:F];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, sector: SEC_0};
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    oms_q   <= oms_d;
    sf_q    <= sf_d;
    s1f_q   <= s1f_d;
    val_q   <= val_i;
    alpha_q <= alpha_i;
  end

  assign ctl_o   = ctl_q;
  assign oms_o   = oms_q;
  assign sf_o    = sf_q;
  assign s1f_o   = s1f_q;
  assign val_o   = val_q;
  assign alpha_o = alpha_q;

endmodule

>>> sv/hsv2rgb_mix.sv
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// Stage 3: the three value products p, q and t.
// ----------------------------------------------------------------------------
module hsv2rgb_mix #(
  parameter int unsigned CHANNEL_FRAC_BITS = hsv2rgb_pkg::CHANNEL_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hsv2rgb_pkg::hsv2rgb_ctl_t        ctl_i,
  input  logic [CHANNEL_FRAC_BITS:0]       oms_i,
  input  logic [CHANNEL_FRAC_BITS:0]       sf_i,
  input  logic [CHANNEL_FRAC_BITS:0]       s1f_i,
  input  logic [CHANNEL_FRAC_BITS:0]       val_i,
  input  logic [hsv2rgb_pkg::CH_W-1:0]     alpha_i,
  output hsv2rgb_pkg::hsv2rgb_ctl_t        ctl_o,
  output logic [CHANNEL_FRAC_BITS:0]       p_o,
  output logic [CHANNEL_FRAC_BITS:0]       q_o,
  output logic [CHANNEL_FRAC_BITS:0]       t_o,
  output logic [CHANNEL_FRAC_BITS:0]       val_o,
  output logic [hsv2rgb_pkg::CH_W-1:0]     alpha_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned F = CHANNEL_FRAC_BITS;
  localparam logic [F:0] ONE_C = (F + 1)'(1) << F;

  logic [F:0]       q_fac, t_fac;
  logic [2*F+1:0]   p_prod, q_prod, t_prod;
  logic [F:0]       p_q, q_q, t_q, val_q;
  logic [CH_W-1:0]  alpha_q;
  hsv2rgb_ctl_t     ctl_q;

  always_comb begin
    q_fac  = ONE_C - sf_i;
    t_fac  = ONE_C - s1f_i;
    p_prod = val_i * oms_i;
    q_prod = val_i * q_fac;
    t_prod = val_i * t_fac;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, sector: SEC_0};
    end else begin
      ctl_q <= ctl_i;
    end
  end

  // products never exceed one squared, so bit 2F+1 is always clear
  always_ff @(posedge clk_i) begin
    p_q     <= p_prod[2*F:F];
    q_q     <= q_prod[2*F:F];
    t_q     <= t_prod[2*F:F];
    val_q   <= val_i;
    alpha_q <= alpha_i;
  end

  assign ctl_o   = ctl_q;
  assign p_o     = p_q;
  assign q_o     = q_q;
  assign t_o     = t_q;
  assign val_o   = val_q;
  assign alpha_o = alpha_q;

endmodule

>>> tb/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter
// Drives HSVA pixels into the converter with random idle gaps, predicts each
// RGBA result in fixed point and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;
  import hsv2rgb_pkg::*;

  localparam int unsigned FRAC = CHANNEL_FRAC_BITS_DEF;
  localparam logic [31:0] ONE_FX = 32'd1 << FRAC;
  localparam int unsigned N_RANDOM = 400;

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
    logic [CH_W-1:0]  alpha;
  } hsva_t;

  typedef struct {
    hsva_t       px;
    int unsigned gap;  // idle cycles before this pixel
  } pending_t;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } rgba_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [HUE_W-1:0] hue_i = '0;
  logic [CH_W-1:0]  saturation_i = '0;
  logic [CH_W-1:0]  brightness_i = '0;
  logic [CH_W-1:0]  alpha_in_i = '0;
  logic             valid_o;
  logic [CH_W-1:0]  red_o;
  logic [CH_W-1:0]  green_o;
  logic [CH_W-1:0]  blue_o;
  logic [CH_W-1:0]  alpha_out_o;

  pending_t    pending_px[$];
  rgba_t       expected_rgba[$];
  pending_t    nxt;
  rgba_t       want;
  logic        taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned sector_hits[6] = '{default: 0};

  hsv_to_rgb_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .brightness_i(brightness_i),
    .alpha_in_i  (alpha_in_i),
    .valid_o     (valid_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_out_o (alpha_out_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // fixed-point hsv to rgb with truncated products
  function automatic rgba_t hsv_to_rgba(hsva_t px);
    logic [31:0] s, v, h6, f, p, q, t;
    sector_e     sec;
    rgba_t       res;
    s   = (px.sat > ONE_FX) ? ONE_FX : 32'(px.sat);
    v   = (px.val > ONE_FX) ? ONE_FX : 32'(px.val);
    h6  = 32'(px.hue) * 32'd6;
    sec = sector_e'(h6[18:16]);
    f   = {16'd0, h6[15:0]} >> (HUE_W - FRAC);
    p   = (v * (ONE_FX - s)) >> FRAC;
    q   = (v * (ONE_FX - ((s * f) >> FRAC))) >> FRAC;
    t   = (v * (ONE_FX - ((s * (ONE_FX - f)) >> FRAC))) >> FRAC;
    case (sec)
      SEC_1: begin
        res.red = CH_W'(q); res.green = CH_W'(v); res.blue = CH_W'(p);
      end
      SEC_2: begin
        res.red = CH_W'(p); res.green = CH_W'(v); res.blue = CH_W'(t);
      end
      SEC_3: begin
        res.red = CH_W'(p); res.green = CH_W'(q); res.blue = CH_W'(v);
      end
      SEC_4: begin
        res.red = CH_W'(t); res.green = CH_W'(p); res.blue = CH_W'(v);
      end
      SEC_5: begin
        res.red = CH_W'(v); res.green = CH_W'(p); res.blue = CH_W'(q);
      end
      default: begin
        res.red = CH_W'(v); res.green = CH_W'(t); res.blue = CH_W'(p);
      end
    endcase
    res.alpha = px.alpha;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    n_errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic queue_pixel(int unsigned h, int unsigned s, int unsigned v,
                             int unsigned a, int unsigned gap);
    pending_t item;
    item.px.hue   = HUE_W'(h);
    item.px.sat   = CH_W'(s);
    item.px.val   = CH_W'(v);
    item.px.alpha = CH_W'(a);
    item.gap      = gap;
    pending_px.push_back(item);
  endtask

  // channel value: mostly in range, some corners, some above 1.0
  function automatic int unsigned draw_channel();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 0;
    if (pick == 1) return ONE_FX;
    if (pick == 2) return 8191;
    if (pick < 5) return $urandom_range(4097, 8191);
    return $urandom_range(0, 4096);
  endfunction

  // driver: once the last pixel is taken, waits out the idle gap, then drives the next on a falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // hold the transaction until the block takes it
    end else if (gap_left != 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_px.size() != 0) begin
      nxt          = pending_px.pop_front();
      hue_i        <= nxt.px.hue;
      saturation_i <= nxt.px.sat;
      brightness_i <= nxt.px.val;
      alpha_in_i   <= nxt.px.alpha;
      start        <= 1'b1;
      gap_left     <= (pending_px.size() != 0) ? pending_px[0].gap : 0;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: record accepted pixels and check each strobed result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        if (expected_rgba.size() == 0) begin
          report_mismatch($sformatf("result with no pixel pending: r=%0d g=%0d b=%0d a=%0d",
                                    red_o, green_o, blue_o, alpha_out_o));
        end else begin
          want = expected_rgba.pop_front();
          n_checked++;
          if (red_o !== want.red)
            report_mismatch($sformatf("red got %0d want %0d", red_o, want.red));
          if (green_o !== want.green)
            report_mismatch($sformatf("green got %0d want %0d", green_o, want.green));
          if (blue_o !== want.blue)
            report_mismatch($sformatf("blue got %0d want %0d", blue_o, want.blue));
          if (alpha_out_o !== want.alpha)
            report_mismatch($sformatf("alpha got %0d want %0d", alpha_out_o, want.alpha));
        end
      end
      if (start && !busy) begin
        expected_rgba.push_back(hsv_to_rgba('{hue_i, saturation_i, brightness_i,
                                              alpha_in_i}));
        sector_hits[(32'(hue_i) * 32'd6) >> 16]++;
        n_sent++;
      end
    end
    taken <= rst_ni && start && !busy;
  end

  initial begin
    int unsigned edge_hues[11] = '{0, 10922, 10923, 21845, 21846, 32768,
                                   43690, 43691, 54613, 54614, 65535};
    int unsigned mode;
    int unsigned gap;
    int unsigned h;

    // sector boundaries at full saturation and brightness, back to back
    foreach (edge_hues[i]) queue_pixel(edge_hues[i], 4096, 4096, i * 400, 0);
    queue_pixel(5461, 0, 4096, 4096, 0);      // gray, no saturation
    queue_pixel(38000, 4096, 0, 0, 1);        // black
    queue_pixel(60000, 8191, 8191, 8191, 0);  // both clamp, alpha over range
    queue_pixel(20000, 4097, 5000, 6000, 3);
    queue_pixel(5461, 2048, 3000, 1, 0);
    queue_pixel(65535, 1, 1, 4095, 2);
    queue_pixel(32767, 4095, 4095, 4097, 0);
    queue_pixel(49151, 2730, 4096, 2048, 14);

    // random pixels in runs with different idle patterns
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i % 40 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0:       gap = 0;
        1:       gap = $urandom_range(0, 14);
        default: gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        h = ($urandom_range(0, 5) * 65536 + 5) / 6 + $urandom_range(0, 2) - 1;
        h = h & 16'hffff;
      end else begin
        h = $urandom_range(0, 65535);
      end
      queue_pixel(h, draw_channel(), draw_channel(), draw_channel(), gap);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_px.size() != 0 || start) @(posedge clk_i);
    while (expected_rgba.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("sent %0d pixels, checked %0d results, %0d mismatches",
             n_sent, n_checked, n_errors);
    $display("pixels per hue sector: %0d %0d %0d %0d %0d %0d", sector_hits[0],
             sector_hits[1], sector_hits[2], sector_hits[3], sector_hits[4],
             sector_hits[5]);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("timeout with %0d results outstanding", expected_rgba.size());
    $display("FAIL");
    $finish;
  end

endmodule
